FILE: hw/rtl/zte_pkg.sv
// zte_pkg: shared types and constants for the z-character text encoder
// no dependencies; used by the interfaces, the packer and the top level
package zte_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned TEXT_W      = 48;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned VER_W       = 4;

  localparam logic [POS_W-1:0] POS_ABSENT = 7'd127;
  localparam logic [POS_W-1:0] ALPHA_SIZE = 7'd78;
  localparam logic [POS_W-1:0] ROW_LEN    = 7'd26;

  localparam logic [4:0] ZC_PAD  = 5'd5;
  localparam logic [4:0] ZC_BASE = 5'd6;

  localparam logic [VER_W-1:0] VER_RESET = 4'd5;

  // config register indexes
  localparam logic REG_VERSION = 1'b0;

  // bit offset of each z-character slot within the 48-bit text word
  localparam int unsigned NUM_SLOTS = 9;
  localparam logic [5:0] ZC_SHIFT [NUM_SLOTS] = '{
    6'd42, 6'd37, 6'd32, 6'd26, 6'd21, 6'd16, 6'd10, 6'd5, 6'd0
  };

  // end-bit positions in the 48-bit text word
  localparam int unsigned END_BIT_SHORT = 31;
  localparam int unsigned END_BIT_LONG  = 15;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  pos;
  } zte_item_t;

endpackage

FILE: hw/rtl/zte_in_if.sv
// zte_in_if: input channel carrying one command transaction
// depends on zte_pkg for field widths
interface zte_in_if import zte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  table_pos;

  modport source (output valid, action, char_code, table_pos, input ready);
  modport sink (input valid, action, char_code, table_pos, output ready);
endinterface

FILE: hw/rtl/zte_out_if.sv
// zte_out_if: output channel carrying one encoded text transaction
// depends on zte_pkg for field widths
interface zte_out_if import zte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] encoded_text;

  modport source (output valid, encoded_text, input ready);
  modport sink (input valid, encoded_text, output ready);
endinterface

FILE: hw/rtl/zte_ram.sv
// zte_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module zte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/zte_packer.sv
// zte_packer: builds the z-character string and forms the finished text word
// depends on zte_pkg
module zte_packer import zte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  zte_item_t         item,
  input  logic [VER_W-1:0]  version,
  output logic [TEXT_W-1:0] text,
  output logic [COUNT_W-1:0] count
);

  logic [TEXT_W-1:0]  buffer;
  logic [TEXT_W-1:0]  buffer_next;
  logic [COUNT_W-1:0] count_next;

  logic              short_fmt;
  logic [4:0]        shift_base;
  logic [COUNT_W-1:0] limit;
  logic              in_alpha;
  logic [1:0]        row;
  logic [POS_W-1:0]  col;
  logic [4:0]        zs [4];
  logic [2:0]        nz;
  logic [TEXT_W-1:0] placed;
  logic [TEXT_W-1:0] padded;
  logic [3:0]        j;

  assign short_fmt  = (version <= 4'd3);
  assign shift_base = (version <= 4'd2) ? 5'd1 : 5'd3;
  assign limit      = short_fmt ? 4'd6 : 4'd9;
  assign in_alpha   = (item.pos < ALPHA_SIZE);

  always_comb begin
    if (item.pos >= 7'(2 * ROW_LEN)) begin
      row = 2'd2;
      col = item.pos - 7'(2 * ROW_LEN);
    end else if (item.pos >= ROW_LEN) begin
      row = 2'd1;
      col = item.pos - ROW_LEN;
    end else begin
      row = 2'd0;
      col = item.pos;
    end
  end

  // up to four z-characters for one input character
  always_comb begin
    zs[0] = '0;
    zs[1] = '0;
    zs[2] = '0;
    zs[3] = '0;
    if (in_alpha) begin
      if (row != 2'd0) begin
        zs[0] = shift_base + 5'(row);
        zs[1] = col[4:0] + ZC_BASE;
        nz    = 3'd2;
      end else begin
        zs[0] = col[4:0] + ZC_BASE;
        nz    = 3'd1;
      end
    end else begin
      // escape form: shift, escape code, then the character in two pieces
      zs[0] = shift_base + 5'd2;
      zs[1] = ZC_BASE;
      zs[2] = 5'(item.char_code[7:5]);
      zs[3] = item.char_code[4:0];
      nz    = 3'd4;
    end
  end

  // slots beyond the ninth fall outside the text word and are dropped
  always_comb begin
    placed = buffer;
    padded = buffer;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      j = 4'(i) - count;
      if (4'(i) >= count && j < 4'(nz)) begin
        placed = placed | (TEXT_W'(zs[j[1:0]]) << ZC_SHIFT[i]);
      end
      if (4'(i) >= count && 4'(i) < limit) begin
        padded = padded | (TEXT_W'(ZC_PAD) << ZC_SHIFT[i]);
      end
    end
    if (short_fmt) begin
      padded[END_BIT_SHORT] = 1'b1;
    end else begin
      padded[END_BIT_LONG] = 1'b1;
    end
  end

  assign text = padded;

  always_comb begin
    buffer_next = buffer;
    count_next  = count;
    if (advance) begin
      case (item.action)
        ACT_ENCODE: begin
          if (count < limit) begin
            buffer_next = placed;
            count_next  = count + 4'(nz);
          end
        end
        ACT_FINISH: begin
          buffer_next = '0;
          count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      count  <= '0;
    end else begin
      buffer <= buffer_next;
      count  <= count_next;
    end
  end

endmodule

FILE: hw/rtl/zchar_text_encoder.sv
// zchar_text_encoder: top level; alphabet table, input stage, packer, output register
// depends on zte_pkg, zte_in_if, zte_out_if, zte_ram, zte_packer
//
//  channel  | dir | payload                          | transaction
//  in_ch    | in  | action, char_code, table_pos     | valid && ready
//  out_ch   | out | encoded_text                     | valid && ready
//  apb      | in  | machine_version at byte addr 0   | psel && penable && pwrite
//
// one item per cycle unless a finish is blocked: an item is accepted, then the
// table read and the packing happen in the following cycle; a finish's text is
// held in the output register; the alphabet table is a 256x7 RAM; per-entry valid
// bits give the absent value after reset with no clearing pass
// a finish waits in the input stage only while the output register is held by
// the sink; loads and encodes never stall
module zchar_text_encoder import zte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  zte_in_if.sink      in_ch,
  zte_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VER_W-1:0] version;

  logic              in_take;
  logic              s1_valid;
  logic              s1_adv;
  logic [1:0]        s1_action;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_pos_valid;
  logic [POS_W-1:0]  ram_rdata;
  zte_item_t         s1_item;

  logic [TABLE_DEPTH-1:0] pos_valid;

  logic              out_valid;
  logic              out_free;
  logic [TEXT_W-1:0] out_text;
  logic [TEXT_W-1:0] fin_text;
  logic [COUNT_W-1:0] zc_count;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERSION) ? 32'(version) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= VER_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERSION) begin
      version <= pwdata[VER_W-1:0];
    end
  end

  // handshake
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && (s1_action != ACT_FINISH || out_free);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // alphabet table; loads write at accept, so a later read sees them
  zte_ram #(
    .WIDTH(POS_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (in_take && in_ch.action == ACT_LOAD),
    .waddr(in_ch.char_code),
    .wdata(in_ch.table_pos),
    .re   (in_take),
    .raddr(in_ch.char_code),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= '0;
    end else if (in_take && in_ch.action == ACT_LOAD) begin
      pos_valid[in_ch.char_code] <= 1'b1;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action    <= in_ch.action;
      s1_char      <= in_ch.char_code;
      s1_pos_valid <= pos_valid[in_ch.char_code];
    end
  end

  assign s1_item.action    = s1_action;
  assign s1_item.char_code = s1_char;
  assign s1_item.pos       = s1_pos_valid ? ram_rdata : POS_ABSENT;

  zte_packer u_packer (
    .clk    (clk),
    .rst    (rst),
    .advance(s1_adv),
    .item   (s1_item),
    .version(version),
    .text   (fin_text),
    .count  (zc_count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_action == ACT_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_action == ACT_FINISH) begin
      out_text <= fin_text;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.encoded_text = out_text;

  // at most one full character past the limit of nine
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    zc_count <= 4'd12)
    else $error("z-character count out of range");

  // input stalls only behind a finish blocked by a held output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && s1_action == ACT_FINISH && out_valid && !out_ch.ready))
    else $error("input stalled without a blocked finish");

  // a finish that moves on leaves an empty string behind and loads the output
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_action == ACT_FINISH) |=> (zc_count == '0 && out_valid))
    else $error("finish did not clear the string or load the output");

  // new output only from a finish
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv && s1_action == ACT_FINISH))
    else $error("output raised without a finish");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for zchar_text_encoder; drives commands, predicts encoded text
// depends on zte_pkg, zte_in_if, zte_out_if and the encoder rtl
module tb;
  import zte_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;
  localparam logic [2:0] VER_ADDR = 3'(REG_VERSION) << 2;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  zte_in_if  in_ch ();
  zte_out_if out_ch ();

  zchar_text_encoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // encoder state as seen by the bench
  logic [POS_W-1:0]   alpha_pos [TABLE_DEPTH];
  logic [COUNT_W-1:0] zc_placed;
  logic [63:0]        string_buf;
  logic [VER_W-1:0]   cur_version;

  zte_item_t         cmd_pending [$];
  logic [TEXT_W-1:0] text_expected [$];
  logic [CHAR_W-1:0] known_chars [$];
  zte_item_t         next_cmd;
  logic [TEXT_W-1:0] text_want;

  int items_sent;
  int items_taken;
  int texts_seen;
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_done;
  int idle_cycles;
  int ver_list [8] = '{1, 8, 3, 4, 2, 0, 15, 9};

  function automatic void put_zchar(logic [4:0] z);
    int unsigned n;
    int unsigned sh;
    n = zc_placed;
    if (n >= 12) return;
    sh = 48 - 16 * (n / 3) + 5 * (2 - n % 3);
    string_buf |= 64'(z) << sh;
    zc_placed = zc_placed + 1'b1;
  endfunction

  function automatic void apply_cmd(zte_item_t it);
    int unsigned p;
    int unsigned row;
    int unsigned shift_base;
    int unsigned zlimit;
    shift_base = (cur_version <= 2) ? 1 : 3;
    zlimit     = (cur_version <= 3) ? 6 : 9;
    case (it.action)
      ACT_LOAD: begin
        alpha_pos[it.char_code] = it.pos;
      end
      ACT_ENCODE: begin
        p = alpha_pos[it.char_code];
        if (zc_placed < zlimit) begin
          if (p < ALPHA_SIZE) begin
            row = p / ROW_LEN;
            if (row > 0) put_zchar(5'(shift_base + row));
            put_zchar(5'(p % ROW_LEN + ZC_BASE));
          end else begin
            // escape form: shift, 6, then the character split 3+5
            put_zchar(5'(shift_base + 2));
            put_zchar(ZC_BASE);
            put_zchar(5'(it.char_code >> 5));
            put_zchar(5'(it.char_code & 8'h1f));
          end
        end
      end
      ACT_FINISH: begin
        while (zc_placed < zlimit) put_zchar(ZC_PAD);
        string_buf |= 64'h80 << (56 - 8 * ((cur_version <= 3) ? 2 : 4));
        text_expected.push_back(string_buf[63:16]);
        zc_placed  = '0;
        string_buf = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic queue_cmd(input logic [1:0] a, input logic [7:0] c, input logic [6:0] p);
    cmd_pending.push_back(zte_item_t'{a, c, p});
    if (a == ACT_LOAD && p < ALPHA_SIZE) known_chars.push_back(c);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_sent) @(posedge clk);
    while (text_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_version(input logic [VER_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VER_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_version = v;
  endtask

  function automatic logic [7:0] pick_char();
    if (known_chars.size() != 0 && $urandom_range(9) < 7)
      return known_chars[$urandom_range(known_chars.size() - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic gen_phase(input int budget);
    int cnt;
    int r;
    int len;
    int a;
    cnt = 0;
    while (cnt < budget) begin
      r = $urandom_range(99);
      if (r < 6) begin
        // noise, including the unused action code
        a = $urandom_range(3);
        queue_cmd(2'(a), 8'($urandom_range(255)), 7'($urandom_range(127)));
        if (2'(a) != ACT_NOP) cnt++;
      end else if (r < 18) begin
        queue_cmd(ACT_LOAD, 8'($urandom_range(255)),
                  ($urandom_range(1) != 0) ? 7'($urandom_range(77)) : 7'($urandom_range(127)));
        cnt++;
      end else begin
        len = (r < 30) ? $urandom_range(10) : $urandom_range(4);
        for (int i = 0; i < len; i++) queue_cmd(ACT_ENCODE, pick_char(), 7'($urandom_range(127)));
        cnt += len;
        // now and then a string is left open into the next one
        if ($urandom_range(9) != 0) begin
          queue_cmd(ACT_FINISH, 8'($urandom_range(255)), 7'($urandom_range(127)));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus and phase control
  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = '0;
    in_ch.char_code = '0;
    in_ch.table_pos = '0;
    out_ch.ready  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) alpha_pos[i] = POS_ABSENT;
    zc_placed     = '0;
    string_buf    = '0;
    cur_version   = VER_RESET;
    send_idle_pct = 20;
    recv_idle_pct = 52;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty string, escapes with spill past the limit, table edges
    queue_cmd(ACT_FINISH, 8'h00, 7'h00);
    queue_cmd(ACT_ENCODE, 8'hff, 7'h7f);
    queue_cmd(ACT_ENCODE, 8'h00, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h41, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h42, 7'h00);
    queue_cmd(ACT_FINISH, 8'hff, 7'h7f);
    queue_cmd(ACT_LOAD, 8'h61, 7'd0);
    queue_cmd(ACT_LOAD, 8'h7a, 7'd25);
    queue_cmd(ACT_LOAD, 8'h41, 7'd26);
    queue_cmd(ACT_LOAD, 8'h5a, 7'd51);
    queue_cmd(ACT_LOAD, 8'h2e, 7'd52);
    queue_cmd(ACT_LOAD, 8'h21, 7'd77);
    queue_cmd(ACT_LOAD, 8'h22, 7'd78);
    queue_cmd(ACT_LOAD, 8'h23, 7'd127);
    queue_cmd(ACT_ENCODE, 8'h61, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h41, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h2e, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h21, 7'h00);
    queue_cmd(ACT_FINISH, 8'h00, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h7a, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h5a, 7'h00);
    queue_cmd(ACT_ENCODE, 8'h22, 7'h00);
    queue_cmd(ACT_NOP, 8'h23, 7'h7f);
    queue_cmd(ACT_FINISH, 8'h00, 7'h00);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 52;
      end else if (ph < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_version(4'(ver_list[ph]));
      gen_phase(115);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // command driver; predicts at each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(zte_item_t'{in_ch.action, in_ch.char_code, in_ch.table_pos});
        items_taken <= items_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_pending.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.action    <= next_cmd.action;
          in_ch.char_code <= next_cmd.char_code;
          in_ch.table_pos <= next_cmd.pos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // text monitor and sink backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        texts_seen++;
        if (text_expected.size() == 0) begin
          $error("encoded_text with nothing expected: actual %h", out_ch.encoded_text);
          mismatches++;
        end else begin
          text_want = text_expected.pop_front();
          if (out_ch.encoded_text !== text_want) begin
            $error("encoded_text mismatch: expected %h, actual %h",
                   text_want, out_ch.encoded_text);
            mismatches++;
          end
        end
      end
      // one long hold so finishes back up into the input stage
      if (!hold_done && texts_seen == 30) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: sim.f
hw/rtl/zte_pkg.sv
hw/rtl/zte_in_if.sv
hw/rtl/zte_out_if.sv
hw/rtl/zte_ram.sv
hw/rtl/zte_packer.sv
hw/rtl/zchar_text_encoder.sv
test/tb.sv
